// File: rtl/rcsc_pkg.sv
package rcsc_pkg;

  localparam int OFFSET_SAMPLES_DEF = 32;
  localparam int PULSE_BITS_DEF     = 12;

  localparam int PULSE_W = 12;
  localparam int REG_W   = 12;
  localparam int ACC_W   = 18;
  localparam int PEAK_W  = 13;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int CH_N    = 4;

  localparam int NUM_W  = 27;
  localparam int DEN_W  = 12;
  localparam int QUOT_W = 15;
  localparam int ITER_W = 5;

  localparam logic [QUOT_W-1:0] FULL_SCALE = 15'd16384;
  localparam logic [REG_W-1:0]  RANGE_MAX  = 12'd4095;

  localparam logic [REG_W-1:0] RESET_OFFSET [CH_N] = '{12'd1520, 12'd1520, 12'd1520, 12'd1520};
  localparam logic [REG_W-1:0] RESET_RANGE  [CH_N] = '{12'd798, 12'd736, 12'd760, 12'd754};

  localparam logic [REG_W-1:0] RESET_THR_MIN   = 12'd1400;
  localparam logic [REG_W-1:0] RESET_THR_MAX   = 12'd1640;
  localparam logic [REG_W-1:0] RESET_STICK_MIN = 12'd1400;
  localparam logic [REG_W-1:0] RESET_STICK_MAX = 12'd1640;
  localparam logic [REG_W-1:0] RESET_MIN_SPAN  = 12'd400;
  localparam logic [REG_W-1:0] RESET_AUX_THR   = 12'd1000;

  typedef enum logic [1:0] {
    ACT_NORM   = 2'd0,
    ACT_OFFSET = 2'd1,
    ACT_RANGE  = 2'd2,
    ACT_FINISH = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    REG_THR_MIN   = 3'd0,
    REG_THR_MAX   = 3'd1,
    REG_STICK_MIN = 3'd2,
    REG_STICK_MAX = 3'd3,
    REG_MIN_SPAN  = 3'd4,
    REG_AUX_THR   = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_RATIO_GO,
    S_RATIO_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic              ovf;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

// File: rtl/rcsc_div.sv
module rcsc_div (
  input  logic               clk,
  input  logic               rst,
  input  rcsc_pkg::div_req_t req,
  output rcsc_pkg::div_rsp_t rsp
);
  import rcsc_pkg::*;

  logic [NUM_W-1:0]  num_sr;
  logic [DEN_W-1:0]  den;
  logic [DEN_W-1:0]  rem;
  logic [QUOT_W-1:0] quot;
  logic              ovf;
  logic              busy;
  logic              done;
  logic [ITER_W-1:0] cnt;

  logic [DEN_W:0] rem_sh;
  logic           ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh = {rem, num_sr[NUM_W-1]};
    ge     = rem_sh >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == ITER_W'(NUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_sr <= req.num;
      den    <= req.den;
      rem    <= '0;
      quot   <= '0;
      ovf    <= 1'b0;
      cnt    <= '0;
    end else if (busy) begin
      num_sr <= {num_sr[NUM_W-2:0], 1'b0};
      rem    <= ge ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
      quot   <= {quot[QUOT_W-2:0], ge};
      // a set bit shifted out of the top means quotient past 15 bits
      ovf    <= ovf | quot[QUOT_W-1];
      cnt    <= cnt + ITER_W'(1);
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.ovf  = ovf;
  assign rsp.quot = quot;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider started while busy");

  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("divider done while still busy");

endmodule

// File: rtl/rc_stick_calibrate_normalize.sv
// a request runs update, four ratio divisions and output load; a request that
//   closes an offset average runs four extra divisions (the offset means) first
// a new request is taken only once the last result is loaded into the output
//   register; the shared 27-step radix-2 divider runs every division
// reset: synchronous, active high; restores registers and calibration defaults
module rc_stick_calibrate_normalize #(
  parameter int OFFSET_SAMPLES = rcsc_pkg::OFFSET_SAMPLES_DEF,
  parameter int PULSE_BITS     = rcsc_pkg::PULSE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // pulse_throttle, pulse_yaw, pulse_pitch, pulse_roll, pulse_aux, zero pad
  input  logic [63:0]                 s_tdata,
  // action
  input  logic [1:0]                  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // throttle_q14, yaw_q14, pitch_q14, roll_q14, aux_on, offsets_ok,
  // ranges_ok, zero pad
  output logic [71:0]                 m_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcsc_pkg::ADDR_W-1:0] paddr,
  input  logic [rcsc_pkg::DATA_W-1:0] pwdata,
  output logic [rcsc_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import rcsc_pkg::*;

  localparam int CNT_W = $clog2(OFFSET_SAMPLES + 1);
  localparam logic [CNT_W-1:0]   SAMPLES_N  = CNT_W'(OFFSET_SAMPLES);
  localparam logic [PULSE_W-1:0] PULSE_MASK = PULSE_W'((1 << PULSE_BITS) - 1);

  state_t state, state_next;

  logic [1:0]         ch;
  act_t               act;
  logic [PULSE_W-1:0] pulse [CH_N];
  logic [PULSE_W-1:0] aux_pulse;

  logic [REG_W-1:0] thr_min, thr_max, stick_min, stick_max, min_span, aux_thr;

  logic [REG_W-1:0]         offset   [CH_N];
  logic [REG_W-1:0]         span     [CH_N];
  logic [ACC_W-1:0]         accum    [CH_N];
  logic [CNT_W-1:0]         count;
  logic signed [PEAK_W-1:0] peak_pos [CH_N];
  logic signed [PEAK_W-1:0] peak_neg [CH_N];
  logic [15:0]              ratio    [CH_N];

  logic        out_valid;
  logic [71:0] out_data;

  logic signed [PEAK_W-1:0] dev       [CH_N];
  logic [REG_W-1:0]         fin_range [CH_N];

  logic [CNT_W-1:0]  count_inc;
  logic              mean_due;
  logic              cfg_wr;
  logic              out_free;
  logic              accept;
  logic              load_out;

  logic signed [PEAK_W-1:0] d_cur;
  logic                     neg_cur;
  logic [PEAK_W-1:0]        mag_wide;
  logic [PULSE_W-1:0]       mag_cur;
  logic [QUOT_W-1:0]        q_sat;
  logic [15:0]              ratio_val;
  logic                     offsets_ok, ranges_ok, aux_on;

  div_req_t div_req;
  div_rsp_t div_rsp;

  rcsc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // per-channel deviation and finish-range values
  always_comb begin
    for (int i = 0; i < CH_N; i++) begin
      logic signed [PEAK_W-1:0] pos, negm, mn;
      logic [PEAK_W:0]          dbl;
      dev[i] = $signed({1'b0, pulse[i]}) - $signed({1'b0, offset[i]});
      pos    = peak_pos[i];
      negm   = -peak_neg[i];
      mn     = (pos >= negm) ? negm : pos;
      dbl    = {mn, 1'b0};
      fin_range[i] = (dbl > (PEAK_W+1)'(RANGE_MAX)) ? RANGE_MAX : dbl[REG_W-1:0];
    end
    // throttle range is the positive peak alone
    fin_range[0] = peak_pos[0][REG_W-1:0];
  end

  assign count_inc = count + CNT_W'(1);
  assign mean_due  = (act == ACT_OFFSET) && (count_inc >= SAMPLES_N);
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign out_free  = !out_valid || m_tready;
  assign accept    = s_tvalid && s_tready;

  // ratio of the channel in work
  always_comb begin
    d_cur    = dev[ch];
    neg_cur  = d_cur[PEAK_W-1];
    mag_wide = neg_cur ? PEAK_W'(-d_cur) : d_cur;
    mag_cur  = mag_wide[PULSE_W-1:0];
    if (span[ch] == '0) begin
      q_sat = (mag_cur != '0) ? FULL_SCALE : '0;
    end else if (div_rsp.ovf || div_rsp.quot > FULL_SCALE) begin
      q_sat = FULL_SCALE;
    end else begin
      q_sat = div_rsp.quot;
    end
    if (ch == 2'd0) begin
      ratio_val = neg_cur ? '0 : {1'b0, q_sat};
    end else begin
      ratio_val = neg_cur ? 16'(-{1'b0, q_sat}) : {1'b0, q_sat};
    end
  end

  always_comb begin
    div_req.start = (state == S_MEAN_GO) || (state == S_RATIO_GO);
    if (state == S_MEAN_GO) begin
      div_req.num = NUM_W'(accum[ch]);
      div_req.den = DEN_W'(OFFSET_SAMPLES);
    end else begin
      div_req.num = (ch == 2'd0) ? {1'b0, mag_cur, 14'b0} : {mag_cur, 15'b0};
      div_req.den = span[ch];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        state_next = mean_due ? S_MEAN_GO : S_RATIO_GO;
      end
      S_MEAN_GO: begin
        state_next = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (div_rsp.done) state_next = (ch == 2'd3) ? S_RATIO_GO : S_MEAN_GO;
      end
      S_RATIO_GO: begin
        state_next = S_RATIO_WAIT;
      end
      S_RATIO_WAIT: begin
        if (div_rsp.done) state_next = (ch == 2'd3) ? S_DONE : S_RATIO_GO;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready = 1'b0;
    load_out = 1'b0;
    case (state)
      S_IDLE:  s_tready = 1'b1;
      S_DONE:  load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_min   <= RESET_THR_MIN;
      thr_max   <= RESET_THR_MAX;
      stick_min <= RESET_STICK_MIN;
      stick_max <= RESET_STICK_MAX;
      min_span  <= RESET_MIN_SPAN;
      aux_thr   <= RESET_AUX_THR;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_THR_MIN:   thr_min   <= pwdata[REG_W-1:0];
        REG_THR_MAX:   thr_max   <= pwdata[REG_W-1:0];
        REG_STICK_MIN: stick_min <= pwdata[REG_W-1:0];
        REG_STICK_MAX: stick_max <= pwdata[REG_W-1:0];
        REG_MIN_SPAN:  min_span  <= pwdata[REG_W-1:0];
        REG_AUX_THR:   aux_thr   <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_THR_MIN:   prdata = DATA_W'(thr_min);
      REG_THR_MAX:   prdata = DATA_W'(thr_max);
      REG_STICK_MIN: prdata = DATA_W'(stick_min);
      REG_STICK_MAX: prdata = DATA_W'(stick_max);
      REG_MIN_SPAN:  prdata = DATA_W'(min_span);
      REG_AUX_THR:   prdata = DATA_W'(aux_thr);
      default:       prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      act       <= act_t'(s_tuser);
      pulse[0]  <= s_tdata[11:0]  & PULSE_MASK;
      pulse[1]  <= s_tdata[23:12] & PULSE_MASK;
      pulse[2]  <= s_tdata[35:24] & PULSE_MASK;
      pulse[3]  <= s_tdata[47:36] & PULSE_MASK;
      aux_pulse <= s_tdata[59:48] & PULSE_MASK;
    end
  end

  // calibration state
  always_ff @(posedge clk) begin
    if (rst) begin
      ch    <= '0;
      count <= '0;
      for (int i = 0; i < CH_N; i++) begin
        offset[i]   <= RESET_OFFSET[i];
        span[i]     <= RESET_RANGE[i];
        accum[i]    <= '0;
        peak_pos[i] <= '0;
        peak_neg[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: ch <= '0;
        S_UPDATE: begin
          case (act)
            ACT_OFFSET: begin
              count <= count_inc;
              for (int i = 0; i < CH_N; i++) begin
                accum[i] <= accum[i] + ACC_W'(pulse[i]);
              end
            end
            ACT_RANGE: begin
              for (int i = 0; i < CH_N; i++) begin
                if (dev[i] > peak_pos[i]) peak_pos[i] <= dev[i];
                if (dev[i] < peak_neg[i]) peak_neg[i] <= dev[i];
              end
            end
            ACT_FINISH: begin
              for (int i = 0; i < CH_N; i++) begin
                span[i]     <= fin_range[i];
                peak_pos[i] <= '0;
                peak_neg[i] <= '0;
              end
            end
            default: ;
          endcase
        end
        S_MEAN_WAIT: begin
          if (div_rsp.done) begin
            offset[ch] <= div_rsp.quot[REG_W-1:0];
            accum[ch]  <= '0;
            ch         <= ch + 2'd1;
            if (ch == 2'd3) count <= '0;
          end
        end
        S_RATIO_WAIT: begin
          if (div_rsp.done) begin
            ratio[ch] <= ratio_val;
            ch        <= ch + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // validity flags
  always_comb begin
    offsets_ok = (offset[0] >= thr_min) && (offset[0] <= thr_max);
    ranges_ok  = 1'b1;
    for (int i = 1; i < CH_N; i++) begin
      if (offset[i] < stick_min || offset[i] > stick_max) offsets_ok = 1'b0;
    end
    for (int i = 0; i < CH_N; i++) begin
      if (span[i] < min_span) ranges_ok = 1'b0;
    end
    aux_on = aux_pulse > aux_thr;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= {6'b0, ranges_ok, offsets_ok, aux_on,
                   ratio[3], ratio[2], ratio[1], ratio[0][QUOT_W-1:0]};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  a_count_below: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (count < SAMPLES_N))
    else $error("offset sample count reached limit while idle");

  a_peak_sign: assert property (@(posedge clk) disable iff (rst)
    !peak_pos[0][PEAK_W-1] && !peak_pos[1][PEAK_W-1] &&
    !peak_pos[2][PEAK_W-1] && !peak_pos[3][PEAK_W-1] &&
    (peak_neg[0] <= 0) && (peak_neg[1] <= 0) &&
    (peak_neg[2] <= 0) && (peak_neg[3] <= 0))
    else $error("peak tracking sign broken");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_MEAN_WAIT || state == S_RATIO_WAIT))
    else $error("divider result outside a wait state");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!m_tvalid || m_tready))
    else $error("output register overwritten");

endmodule

// File: verif/tb_rc_stick_calibrate_normalize.sv
module tb_rc_stick_calibrate_normalize;
  import rcsc_pkg::*;

  typedef struct packed {
    act_t             action;
    logic [11:0]      aux;
    logic [3:0][11:0] pulse;
  } rc_frame_t;

  typedef struct packed {
    logic [14:0]        throttle;
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic               aux_on;
    logic               offsets_ok;
    logic               ranges_ok;
  } stick_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  rc_stick_calibrate_normalize dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // calibration state mirrored by the predictor
  logic [11:0]        cfg [6];
  logic [11:0]        center_off [4];
  logic [11:0]        span [4];
  logic [17:0]        off_sum [4];
  logic [6:0]         n_samples;
  logic signed [12:0] pk_pos [4];
  logic signed [12:0] pk_neg [4];

  rc_frame_t     frames_to_send [$];
  stick_result_t expected_results [$];
  rc_frame_t     frame_on_bus;

  bit          steady = 1'b0;
  int unsigned errors = 0;
  int unsigned n_checked = 0;
  int unsigned n_means = 0;
  int unsigned n_queued = 0;
  int unsigned n_by_action [4] = '{0, 0, 0, 0};

  function automatic logic signed [15:0] q14_ratio(int d, logic [11:0] rng, int unsigned scale);
    int unsigned mag;
    int unsigned q;
    mag = (d < 0) ? -d : d;
    if (rng == 0) q = (mag != 0) ? 16384 : 0;
    else q = (mag * scale) / rng;
    if (q > 16384) q = 16384;
    return (d < 0) ? -$signed(q[15:0]) : $signed(q[15:0]);
  endfunction

  function automatic stick_result_t calibrate_and_normalize(rc_frame_t f);
    stick_result_t res;
    int d, pos, neg, v;
    logic signed [15:0] r;
    case (f.action)
      ACT_OFFSET: begin
        for (int c = 0; c < 4; c++) off_sum[c] = off_sum[c] + 18'(f.pulse[c]);
        n_samples = n_samples + 7'd1;
        if (n_samples >= OFFSET_SAMPLES_DEF) begin
          for (int c = 0; c < 4; c++) begin
            center_off[c] = 12'(off_sum[c] / OFFSET_SAMPLES_DEF);
            off_sum[c] = '0;
          end
          n_samples = '0;
          n_means++;
        end
      end
      ACT_RANGE: begin
        for (int c = 0; c < 4; c++) begin
          d = int'(f.pulse[c]) - int'(center_off[c]);
          if (d > pk_pos[c]) pk_pos[c] = d[12:0];
          if (d < pk_neg[c]) pk_neg[c] = d[12:0];
        end
      end
      ACT_FINISH: begin
        for (int c = 0; c < 4; c++) begin
          pos = pk_pos[c];
          neg = -int'(pk_neg[c]);
          v = ((pos >= neg) ? neg : pos) * 2;
          if (v > 4095) v = 4095;
          span[c] = v[11:0];
        end
        pos = pk_pos[0];
        span[0] = (pos > 4095) ? 12'd4095 : pos[11:0];
        for (int c = 0; c < 4; c++) begin
          pk_pos[c] = '0;
          pk_neg[c] = '0;
        end
      end
      default: ;
    endcase
    r = q14_ratio(int'(f.pulse[0]) - int'(center_off[0]), span[0], 16384);
    res.throttle = (r < 0) ? 15'd0 : r[14:0];
    res.yaw   = q14_ratio(int'(f.pulse[1]) - int'(center_off[1]), span[1], 32768);
    res.pitch = q14_ratio(int'(f.pulse[2]) - int'(center_off[2]), span[2], 32768);
    res.roll  = q14_ratio(int'(f.pulse[3]) - int'(center_off[3]), span[3], 32768);
    res.aux_on = f.aux > cfg[REG_AUX_THR];
    res.offsets_ok = center_off[0] >= cfg[REG_THR_MIN] && center_off[0] <= cfg[REG_THR_MAX];
    res.ranges_ok = 1'b1;
    for (int c = 1; c < 4; c++)
      if (center_off[c] < cfg[REG_STICK_MIN] || center_off[c] > cfg[REG_STICK_MAX])
        res.offsets_ok = 1'b0;
    for (int c = 0; c < 4; c++)
      if (span[c] < cfg[REG_MIN_SPAN]) res.ranges_ok = 1'b0;
    return res;
  endfunction

  function automatic void check_field(string fname, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t mismatch %s expected %0d actual %0d", $time, fname, want, got);
    end
  endfunction

  // frame driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        expected_results.push_back(calibrate_and_normalize(frame_on_bus));
        n_by_action[frame_on_bus.action]++;
      end
      if (frames_to_send.size() > 0 && (steady || $urandom_range(99) >= 13)) begin
        frame_on_bus = frames_to_send.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, frame_on_bus.aux, frame_on_bus.pulse};
        s_tuser <= frame_on_bus.action;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    stick_result_t want;
    m_tready <= steady || $urandom_range(99) >= 13;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result expected none actual %h", $time, m_tdata);
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        check_field("throttle_q14", int'(want.throttle), int'(m_tdata[14:0]));
        check_field("yaw_q14", int'(want.yaw), int'($signed(m_tdata[30:15])));
        check_field("pitch_q14", int'(want.pitch), int'($signed(m_tdata[46:31])));
        check_field("roll_q14", int'(want.roll), int'($signed(m_tdata[62:47])));
        check_field("aux_on", int'(want.aux_on), int'(m_tdata[63]));
        check_field("offsets_ok", int'(want.offsets_ok), int'(m_tdata[64]));
        check_field("ranges_ok", int'(want.ranges_ok), int'(m_tdata[65]));
      end
    end
  end

  task automatic push_frame(act_t a, int thr, int yaw, int pitch, int roll, int aux);
    rc_frame_t f;
    f.action = a;
    f.pulse[0] = thr[11:0];
    f.pulse[1] = yaw[11:0];
    f.pulse[2] = pitch[11:0];
    f.pulse[3] = roll[11:0];
    f.aux = aux[11:0];
    frames_to_send.push_back(f);
    n_queued++;
  endtask

  function automatic int near(int c, int w);
    int v;
    v = c + int'($urandom_range(2 * w)) - w;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  task automatic reg_write(reg_idx_t idx, logic [11:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= ($urandom() & 32'hFFFF_F000) | val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg[idx] = val;
  endtask

  task automatic set_registers(int tmin, int tmax, int smin, int smax, int mspan, int athr);
    reg_write(REG_THR_MIN, tmin[11:0]);
    reg_write(REG_THR_MAX, tmax[11:0]);
    reg_write(REG_STICK_MIN, smin[11:0]);
    reg_write(REG_STICK_MAX, smax[11:0]);
    reg_write(REG_MIN_SPAN, mspan[11:0]);
    reg_write(REG_AUX_THR, athr[11:0]);
  endtask

  task automatic wait_idle();
    while (frames_to_send.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  task automatic queue_random_frames(int n);
    int unsigned first;
    int len, kind, spread;
    int ctr [4];
    first = n_queued;
    while (n_queued - first < n) begin
      kind = $urandom_range(9);
      if (kind < 4) begin
        // offset calibration burst, may stop short of a full average
        len = $urandom_range(4, 36);
        for (int c = 0; c < 4; c++)
          ctr[c] = ($urandom_range(7) == 0) ? $urandom_range(4095) : $urandom_range(1300, 1750);
        for (int k = 0; k < len; k++)
          push_frame(ACT_OFFSET, near(ctr[0], 40), near(ctr[1], 40), near(ctr[2], 40),
                     near(ctr[3], 40), $urandom_range(4095));
      end else if (kind < 7) begin
        // range sweep, a finish on most bursts, then a few normal frames
        len = $urandom_range(2, 12);
        spread = $urandom_range(1) ? 1300 : 600;
        for (int k = 0; k < len; k++)
          push_frame(ACT_RANGE, near(1520, spread), near(1520, spread), near(1520, spread),
                     near(1520, spread), $urandom_range(4095));
        if ($urandom_range(4) != 0)
          push_frame(ACT_FINISH, near(1520, 900), near(1520, 900), near(1520, 900),
                     near(1520, 900), $urandom_range(4095));
        len = $urandom_range(1, 5);
        for (int k = 0; k < len; k++)
          push_frame(ACT_NORM, near(1520, 900), near(1520, 900), near(1520, 900),
                     near(1520, 900), $urandom_range(4095));
      end else begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
          push_frame(act_t'($urandom_range(3)), $urandom_range(4095), $urandom_range(4095),
                     $urandom_range(4095), $urandom_range(4095), $urandom_range(4095));
      end
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb_rc_stick_calibrate_normalize NOT OK");
    $finish;
  end

  initial begin
    int tmin, smin;
    cfg[REG_THR_MIN] = 12'd1400;
    cfg[REG_THR_MAX] = 12'd1640;
    cfg[REG_STICK_MIN] = 12'd1400;
    cfg[REG_STICK_MAX] = 12'd1640;
    cfg[REG_MIN_SPAN] = 12'd400;
    cfg[REG_AUX_THR] = 12'd1000;
    for (int c = 0; c < 4; c++) begin
      center_off[c] = 12'd1520;
      off_sum[c] = '0;
      pk_pos[c] = '0;
      pk_neg[c] = '0;
    end
    span[0] = 12'd798;
    span[1] = 12'd736;
    span[2] = 12'd760;
    span[3] = 12'd754;
    n_samples = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed frames at reset calibration
    push_frame(ACT_NORM, 1520, 1520, 1520, 1520, 1000);
    push_frame(ACT_NORM, 1520, 1520, 1520, 1520, 1001);
    push_frame(ACT_NORM, 0, 0, 0, 0, 0);
    push_frame(ACT_NORM, 4095, 4095, 4095, 4095, 4095);
    push_frame(ACT_NORM, 1919, 1888, 1900, 1897, 2730);
    push_frame(ACT_NORM, 1121, 1152, 1140, 1143, 1365);
    push_frame(ACT_OFFSET, 4095, 4095, 4095, 4095, 0);
    push_frame(ACT_RANGE, 2020, 1900, 1820, 1620, 500);
    push_frame(ACT_RANGE, 1220, 1320, 1020, 1220, 3000);
    push_frame(ACT_NORM, 1820, 1420, 1770, 1330, 1200);
    push_frame(ACT_FINISH, 1620, 1520, 1620, 1420, 900);
    push_frame(ACT_NORM, 2020, 1200, 1500, 4095, 1001);
    push_frame(ACT_RANGE, 4095, 4095, 4095, 4095, 1);
    push_frame(ACT_RANGE, 0, 0, 0, 0, 4094);
    push_frame(ACT_FINISH, 1520, 0, 4095, 1520, 2048);
    // finish with no samples leaves every range at zero
    push_frame(ACT_FINISH, 1600, 1400, 1520, 1521, 1000);
    push_frame(ACT_NORM, 1519, 1520, 1521, 0, 4095);
    push_frame(ACT_RANGE, 1900, 1900, 1900, 1900, 7);
    push_frame(ACT_FINISH, 1700, 1600, 1500, 1400, 8);
    push_frame(ACT_NORM, 1620, 1620, 1620, 1620, 2047);
    wait_idle();

    steady = 1'b1;
    set_registers(1450, 1600, 1380, 1660, $urandom_range(300, 900), 1000);
    queue_random_frames(55);
    wait_idle();
    steady = 1'b0;

    set_registers(0, 0, 0, 0, 0, 0);
    queue_random_frames(55);
    wait_idle();

    set_registers(4095, 4095, 4095, 4095, 4095, 4095);
    queue_random_frames(55);
    wait_idle();

    set_registers(0, 4095, 0, 4095, $urandom_range(4095), $urandom_range(4095));
    queue_random_frames(55);
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      tmin = $urandom_range(1200, 1600);
      smin = $urandom_range(1200, 1600);
      set_registers(tmin, tmin + $urandom_range(400), smin, smin + $urandom_range(400),
                    $urandom_range(1000), $urandom_range(4095));
      queue_random_frames(55);
      wait_idle();
    end

    repeat (300) @(posedge clk);
    $display("checked %0d results: %0d normalize, %0d offset, %0d range, %0d finish frames",
             n_checked, n_by_action[0], n_by_action[1], n_by_action[2], n_by_action[3]);
    $display("%0d offset averages completed across 8 register settings", n_means);
    if (errors == 0) begin
      $display("tb_rc_stick_calibrate_normalize OK");
    end else begin
      $display("tb_rc_stick_calibrate_normalize NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/rcsc_pkg.sv
rtl/rcsc_div.sv
rtl/rc_stick_calibrate_normalize.sv
verif/tb_rc_stick_calibrate_normalize.sv
